/* rtl/fth_pkg.sv */
// ----------------------------------------------------------------------------
// fth_pkg: shared types and constants for the frequency to hue RGB block
// Holds the register map, fixed-point defaults and the channel constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fth_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W      = 32;
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 8'd1;

  localparam logic [SAMPLE_W-1:0] LOW_BOUND_RST  = 32'h0000_0000;
  localparam logic [SAMPLE_W-1:0] HIGH_BOUND_RST = 32'hFFFF_FFFF;

  // channel = floor((918*t + 232*one) / (5*one)), t the ramp in 0..one
  localparam int MUL_C     = 918;
  localparam int ADD_M     = 232;
  localparam int X_W       = 11;
  localparam int RECIP5    = 6554;
  localparam int RECIP_SH  = 15;
  localparam int PROD_W    = 24;

  typedef struct packed {
    logic vld;
    logic zero;
    logic one;
  } ctl_t;

  // Divide a short integer part by five and clamp to one byte.
  function automatic logic [7:0] chan_lvl(input logic [X_W-1:0] x);
    logic [PROD_W-1:0] p;
    logic [PROD_W-RECIP_SH-1:0] q;
    p = PROD_W'(x) * PROD_W'(RECIP5);
    q = p[PROD_W-1:RECIP_SH];
    chan_lvl = (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/fth_norm.sv */
// ----------------------------------------------------------------------------
// fth_norm: bound handling front end
// Sorts out equal, ordered and reversed bounds and forms the dividend
// and divisor of the normalization, or a forced fraction of zero or one.
// ----------------------------------------------------------------------------
`default_nettype none

module fth_norm (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]   low_bound,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]   high_bound,
  output fth_pkg::ctl_t                       out_ctl,
  output logic [fth_pkg::SAMPLE_W-1:0]        out_num,
  output logic [fth_pkg::SAMPLE_W-1:0]        out_den
);

  fth_pkg::ctl_t                 ctl_r, ctl_nxt;
  logic [fth_pkg::SAMPLE_W-1:0]  num_r, num_nxt;
  logic [fth_pkg::SAMPLE_W-1:0]  den_r, den_nxt;

  always_comb begin
    ctl_nxt.vld  = in_vld;
    ctl_nxt.zero = 1'b0;
    ctl_nxt.one  = 1'b0;
    num_nxt      = in_sample - low_bound;
    den_nxt      = high_bound - low_bound;
    if (high_bound == low_bound) begin
      ctl_nxt.zero = (in_sample < low_bound);
      ctl_nxt.one  = !(in_sample < low_bound);
    end else if (high_bound > low_bound) begin
      ctl_nxt.zero = (in_sample < low_bound);
    end else begin
      // reversed bounds: distance measured downward from low
      ctl_nxt.zero = (in_sample > low_bound);
      num_nxt      = low_bound - in_sample;
      den_nxt      = low_bound - high_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_num = num_r;
  assign out_den = den_r;

endmodule

`default_nettype wire

/* rtl/fth_div.sv */
// ----------------------------------------------------------------------------
// fth_div: pipelined restoring divider
// Passes a forced zero, clamps at one when the dividend reaches the divisor,
// else produces one fraction bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fth_div #(
  parameter int FRAC_BITS = fth_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fth_pkg::ctl_t                 in_ctl,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]  in_num,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]  in_den,
  output logic                               out_vld,
  output logic [FRAC_BITS:0]                 out_frac
);

  localparam int SW = fth_pkg::SAMPLE_W;

  fth_pkg::ctl_t     ctl_r [0:FRAC_BITS];
  logic [SW-1:0]     rem_r [0:FRAC_BITS];
  logic [SW-1:0]     den_r [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] q_r [0:FRAC_BITS];

  // entry stage: decide the clamp at one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0].vld  <= in_ctl.vld;
      ctl_r[0].zero <= in_ctl.zero;
      ctl_r[0].one  <= in_ctl.one | (!in_ctl.zero && (in_num >= in_den));
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    q_r[0]   <= '0;
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
    logic [SW:0]          rem2;
    logic                 ge;
    logic [SW:0]          diff;
    logic [SW-1:0]        rem_nxt;
    logic [FRAC_BITS-1:0] q_nxt;

    always_comb begin
      rem2    = {rem_r[i-1], 1'b0};
      diff    = rem2 - {1'b0, den_r[i-1]};
      ge      = (rem2 >= {1'b0, den_r[i-1]});
      rem_nxt = ge ? diff[SW-1:0] : rem2[SW-1:0];
      q_nxt   = {q_r[i-1][FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_r[i-1];
      q_r[i]   <= q_nxt;
    end
  end

  assign out_vld  = ctl_r[FRAC_BITS].vld;
  assign out_frac = ctl_r[FRAC_BITS].zero ? '0 :
                    ctl_r[FRAC_BITS].one  ? {1'b1, {FRAC_BITS{1'b0}}} :
                                            {1'b0, q_r[FRAC_BITS]};

endmodule

`default_nettype wire

/* rtl/fth_color.sv */
// ----------------------------------------------------------------------------
// fth_color: hue to RGB back end
// Splits the fraction into sector and ramp, scales the ramp into a
// channel level and places the levels by sector.
// ----------------------------------------------------------------------------
`default_nettype none

module fth_color #(
  parameter int FRAC_BITS = fth_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  input  wire logic [FRAC_BITS:0]   in_frac,
  output logic                      out_vld,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue
);

  localparam int SC_W = FRAC_BITS + 4;
  localparam int W_W  = FRAC_BITS + fth_pkg::X_W;
  localparam int XW   = fth_pkg::X_W;
  localparam logic [7:0] CV =
    fth_pkg::chan_lvl(XW'(fth_pkg::MUL_C + fth_pkg::ADD_M));
  localparam logic [7:0] ZV = fth_pkg::chan_lvl(XW'(fth_pkg::ADD_M));

  // stage 1: sector and ramp
  logic [SC_W-1:0]    scaled;
  logic [2:0]         sec_nxt;
  logic [FRAC_BITS:0] ramp_nxt;
  logic               vld1_r;
  logic [2:0]         sec1_r;
  logic [FRAC_BITS:0] ramp_r;

  always_comb begin
    scaled   = ({3'b000, in_frac} << 2) + {3'b000, in_frac};
    sec_nxt  = scaled[FRAC_BITS+2:FRAC_BITS];
    ramp_nxt = sec_nxt[0] ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, scaled[FRAC_BITS-1:0]})
                          : {1'b0, scaled[FRAC_BITS-1:0]};
  end

  // stage 2: integer part of the scaled ramp
  logic [W_W-1:0] w;
  logic           vld2_r;
  logic [2:0]     sec2_r;
  logic [XW-1:0]  x_r;

  always_comb begin
    w = W_W'(ramp_r) * W_W'(fth_pkg::MUL_C) + (W_W'(fth_pkg::ADD_M) << FRAC_BITS);
  end

  // stage 3: divide by five and place by sector
  logic [7:0] xv;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic       vld3_r;
  logic [7:0] red_r, green_r, blue_r;

  always_comb begin
    xv = fth_pkg::chan_lvl(x_r);
    case (sec2_r)
      3'd0: begin
        red_nxt = CV; green_nxt = xv; blue_nxt = ZV;
      end
      3'd1: begin
        red_nxt = xv; green_nxt = CV; blue_nxt = ZV;
      end
      3'd2: begin
        red_nxt = ZV; green_nxt = CV; blue_nxt = xv;
      end
      3'd3: begin
        red_nxt = ZV; green_nxt = xv; blue_nxt = CV;
      end
      3'd4: begin
        red_nxt = xv; green_nxt = ZV; blue_nxt = CV;
      end
      default: begin
        red_nxt = CV; green_nxt = ZV; blue_nxt = xv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    sec1_r  <= sec_nxt;
    ramp_r  <= ramp_nxt;
    sec2_r  <= sec1_r;
    x_r     <= w[W_W-1:FRAC_BITS];
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_vld   = vld3_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

/* rtl/frequency_to_hue_rgb.sv */
// Pipeline: FRAC_BITS + 5 register stages, the first loaded at the accepting
// edge and the last driving the result strobe.
// Throughput: one sample per cycle; busy stays low, the divider takes one
// quotient bit per pipeline stage so every stage accepts a new beat each cycle.
// Results leave on out_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears all valid bits and sets low_bound
// to 0 and high_bound to all ones.
// ----------------------------------------------------------------------------
// frequency_to_hue_rgb: frequency sample to RGB colour
// Normalizes a sample between two bounds, maps it to a hue and converts
// it to RGB channel levels with fixed saturation and value.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_to_hue_rgb #(
  parameter int FRAC_BITS = fth_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]    in_freq_sample,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fth_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fth_pkg::SAMPLE_W-1:0]    cfg_data,
  output logic                                 out_valid,
  output logic [7:0]                           out_red_level,
  output logic [7:0]                           out_green_level,
  output logic [7:0]                           out_blue_level,
  output logic [23:0]                          out_packed_rgb
);

  logic [fth_pkg::SAMPLE_W-1:0] low_bound_r;
  logic [fth_pkg::SAMPLE_W-1:0] high_bound_r;

  fth_pkg::ctl_t                norm_ctl;
  logic [fth_pkg::SAMPLE_W-1:0] norm_num;
  logic [fth_pkg::SAMPLE_W-1:0] norm_den;
  logic                         div_vld;
  logic [FRAC_BITS:0]           div_frac;
  logic [7:0]                   red, green, blue;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r  <= fth_pkg::LOW_BOUND_RST;
      high_bound_r <= fth_pkg::HIGH_BOUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unknown indexes
      if (cfg_index == fth_pkg::REG_LOW_BOUND) begin
        low_bound_r <= cfg_data;
      end else if (cfg_index == fth_pkg::REG_HIGH_BOUND) begin
        high_bound_r <= cfg_data;
      end
    end
  end

  fth_norm u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start && !busy),
    .in_sample  (in_freq_sample),
    .low_bound  (low_bound_r),
    .high_bound (high_bound_r),
    .out_ctl    (norm_ctl),
    .out_num    (norm_num),
    .out_den    (norm_den)
  );

  fth_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (norm_ctl),
    .in_num   (norm_num),
    .in_den   (norm_den),
    .out_vld  (div_vld),
    .out_frac (div_frac)
  );

  fth_color #(
    .FRAC_BITS (FRAC_BITS)
  ) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (div_vld),
    .in_frac   (div_frac),
    .out_vld   (out_valid),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue)
  );

  assign out_red_level   = red;
  assign out_green_level = green;
  assign out_blue_level  = blue;
  assign out_packed_rgb  = {red, green, blue};

endmodule

`default_nettype wire

/* tb/sv/frequency_to_hue_rgb_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frequency_to_hue_rgb_tb: self-checking bench for the frequency to RGB block
// Drives samples through the start/busy port and bound registers through the
// cfg port. Each accepted sample is run through a local fixed-point color
// predictor, and every out_valid strobe is compared against the oldest
// prediction. Directed sector, equal-bound and reversed-bound cases come
// first, then random traffic under three sender idle profiles.
// ----------------------------------------------------------------------------

module frequency_to_hue_rgb_tb;

  localparam int FB = fth_pkg::FRAC_BITS_DEF;
  localparam bit [63:0] ONE = 64'd1 << FB;
  localparam int PIPE_DEPTH = FB + 5;
  localparam logic [fth_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hA5;
  localparam logic [31:0] SPAN5 = 32'd5 << FB;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] rgb;
  } color_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [fth_pkg::SAMPLE_W-1:0]  in_freq_sample = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fth_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fth_pkg::SAMPLE_W-1:0]  cfg_data = '0;
  logic                          out_valid;
  logic [7:0]                    out_red_level;
  logic [7:0]                    out_green_level;
  logic [7:0]                    out_blue_level;
  logic [23:0]                   out_packed_rgb;

  // bounds as seen by the block, updated on cfg handshakes
  logic [31:0] lo_bound = fth_pkg::LOW_BOUND_RST;
  logic [31:0] hi_bound = fth_pkg::HIGH_BOUND_RST;
  // bounds last requested, used only to shape stimulus
  logic [31:0] plan_lo = fth_pkg::LOW_BOUND_RST;
  logic [31:0] plan_hi = fth_pkg::HIGH_BOUND_RST;

  color_t color_queue[$];
  int     err_cnt = 0;
  int     sample_cnt = 0;
  int     result_cnt = 0;
  int     setting_cnt = 0;
  int     idle_pct = 0;

  frequency_to_hue_rgb dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_freq_sample  (in_freq_sample),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_packed_rgb  (out_packed_rgb)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Normalized position of a sample between the bounds, 0 .. ONE.
  function automatic bit [63:0] hue_fraction(input logic [31:0] s);
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] q;
    if (hi_bound == lo_bound)
      return (s < lo_bound) ? 64'd0 : ONE;
    if (hi_bound > lo_bound) begin
      if (s < lo_bound)
        return 64'd0;
      num = 64'(s) - 64'(lo_bound);
      den = 64'(hi_bound) - 64'(lo_bound);
    end else begin
      // reversed bounds: samples above low give a negative quotient
      if (s > lo_bound)
        return 64'd0;
      num = 64'(lo_bound) - 64'(s);
      den = 64'(lo_bound) - 64'(hi_bound);
    end
    q = (num << FB) / den;
    return (q > ONE) ? ONE : q;
  endfunction

  // 255 * (0.72 * t / ONE + 0.18), rounded half up, clamped to a byte.
  function automatic logic [7:0] channel_level(input bit [63:0] t);
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] v;
    num = 64'd18360 * t + 64'd4590 * ONE;
    den = 64'd100 * ONE;
    v = (2 * num + den) / (2 * den);
    return (v > 64'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic color_t hue_color(input logic [31:0] s);
    bit [63:0]  scaled;
    bit [63:0]  pos;
    bit [63:0]  ramp;
    int         sector;
    logic [7:0] c;
    logic [7:0] x;
    logic [7:0] z;
    color_t     res;
    scaled = 64'd5 * hue_fraction(s);
    sector = int'(scaled >> FB);
    pos = scaled & (ONE - 1);
    ramp = sector[0] ? ONE - pos : pos;
    c = channel_level(ONE);
    x = channel_level(ramp);
    z = channel_level(64'd0);
    case (sector)
      0: begin res.red = c; res.green = x; res.blue = z; end
      1: begin res.red = x; res.green = c; res.blue = z; end
      2: begin res.red = z; res.green = c; res.blue = x; end
      3: begin res.red = z; res.green = x; res.blue = c; end
      4: begin res.red = x; res.green = z; res.blue = c; end
      default: begin res.red = c; res.green = z; res.blue = x; end
    endcase
    res.rgb = {res.red, res.green, res.blue};
    return res;
  endfunction

  // Track register writes, predict accepted samples, check strobed results.
  always @(posedge clk) begin : scoreboard
    color_t want;
    if (rst_n) begin
      if (out_valid) begin
        result_cnt++;
        if (color_queue.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result rgb %06h", $time, out_packed_rgb);
        end else begin
          want = color_queue.pop_front();
          if (out_red_level !== want.red) begin
            err_cnt++;
            $display("%0t: red expected %0d got %0d", $time, want.red, out_red_level);
          end
          if (out_green_level !== want.green) begin
            err_cnt++;
            $display("%0t: green expected %0d got %0d", $time, want.green, out_green_level);
          end
          if (out_blue_level !== want.blue) begin
            err_cnt++;
            $display("%0t: blue expected %0d got %0d", $time, want.blue, out_blue_level);
          end
          if (out_packed_rgb !== want.rgb) begin
            err_cnt++;
            $display("%0t: packed expected %06h got %06h", $time, want.rgb, out_packed_rgb);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fth_pkg::REG_LOW_BOUND)
          lo_bound = cfg_data;
        else if (cfg_index == fth_pkg::REG_HIGH_BOUND)
          hi_bound = cfg_data;
      end
      if (start && !busy) begin
        sample_cnt++;
        color_queue.push_back(hue_color(in_freq_sample));
      end
    end
  end

  // Drop start and hold until every predicted color has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (color_queue.size() != 0);
  endtask

  // One beat on the sample port; start stays high on return.
  task automatic send_sample(input logic [31:0] s);
    // idle each cycle with the chosen odds
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_freq_sample <= s;
    do @(posedge clk); while (busy);
  endtask

  // One beat on the cfg port; cfg_valid stays high on return.
  task automatic write_reg(input logic [fth_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
    drain();
    write_reg(fth_pkg::REG_LOW_BOUND, lo);
    write_reg(fth_pkg::REG_HIGH_BOUND, hi);
    cfg_valid <= 1'b0;
    plan_lo = lo;
    plan_hi = hi;
    setting_cnt++;
  endtask

  // Walk the six sectors with a span of exactly five fraction units.
  task automatic test_sector_edges();
    logic [31:0] base;
    base = 32'd1000;
    set_bounds(base, base + SPAN5);
    send_sample(32'd0);
    send_sample(base - 1);
    send_sample(base);
    send_sample(base + 32'h0000_8000);
    for (int k = 1; k < 5; k++)
      send_sample(base + (32'(k) << FB));
    send_sample(base + (32'd3 << FB) + 32'd12345);
    send_sample(base + SPAN5 - 1);
    send_sample(base + SPAN5);
    send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_equal_bounds();
    set_bounds(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    set_bounds(32'h0, 32'h0);
    send_sample(32'h0);
    set_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_reversed_bounds();
    set_bounds(32'hFFFF_FFFF, 32'h0);
    send_sample(32'h0);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    set_bounds(32'd5000, 32'd1000);
    send_sample(32'd6000);
    send_sample(32'd3000);
    send_sample(32'd500);
  endtask

  // A write to an unmapped index must leave both bounds alone.
  task automatic test_spare_index();
    drain();
    write_reg(REG_SPARE, 32'h0000_0001);
    cfg_valid <= 1'b0;
    send_sample(32'd3000);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] a;
    logic [31:0] b;
    a = (plan_lo < plan_hi) ? plan_lo : plan_hi;
    b = (plan_lo < plan_hi) ? plan_hi : plan_lo;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return plan_lo + 32'($urandom_range(0, 4)) - 32'd2;
      2: return plan_hi + 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom_range(a, b);
    endcase
  endfunction

  task automatic pick_bounds();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 6))
      0: set_bounds(32'h0, 32'hFFFF_FFFF);
      1: set_bounds((a < b) ? a : b, (a < b) ? b : a);
      2: set_bounds(a, a + 32'($urandom_range(1, 600)));
      3: set_bounds(a, a);
      4: set_bounds((a < b) ? b : a, (a < b) ? a : b);
      5: begin
        a = $urandom_range(0, 1000);
        set_bounds(a, a + SPAN5);
      end
      default: set_bounds(a, b);
    endcase
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0)
        pick_bounds();
      else if ($urandom_range(0, 99) == 0)
        drain();
      send_sample(pick_sample());
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sector_edges();
    test_equal_bounds();
    test_reversed_bounds();
    test_spare_index();
    test_random_traffic(480, 14);
    test_random_traffic(480, 78);
    test_random_traffic(480, 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("Run covered %0d samples and %0d results over %0d bound settings,",
             sample_cnt, result_cnt, setting_cnt);
    $display("  including sector edges, equal, reversed and out-of-range bounds.");
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", color_queue.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
